// ----- sv/multi_pattern_byte_scanner_unit_macros.svh -----
// Assertion macros for the multi-pattern byte scanner.
`ifndef MULTI_PATTERN_BYTE_SCANNER_UNIT_MACROS_SVH
`define MULTI_PATTERN_BYTE_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define MPBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpbs assertion failed");

`define MPBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpbs assertion failed");

`else

`define MPBS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define MPBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- sv/mpbs_pkg.sv -----
// Shared codes, result type and helpers for the multi-pattern byte scanner.
package mpbs_pkg;

  localparam int unsigned FIELD_W = 10;
  localparam int unsigned WORD_W  = 32;
  localparam logic [WORD_W-1:0] WORD_MAX = '1;

  typedef enum logic [1:0] {
    OP_WR_GOTO = 2'd0,
    OP_WR_NODE = 2'd1,
    OP_WR_PAT  = 2'd2,
    OP_SCAN    = 2'd3
  } op_e;

  typedef enum logic {
    KIND_MATCH = 1'b0,
    KIND_END   = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [WORD_W-1:0] id;
    logic [WORD_W-1:0] len;
    logic [WORD_W-1:0] offset;
    logic [WORD_W-1:0] total;
    logic              final_run;
  } res_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] v);
    return (v == WORD_MAX) ? v : v + {{(WORD_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ----- sv/multi_pattern_byte_scanner_unit.sv -----
// Aho-Corasick byte scanner: automaton tables, walk sequencer and result register.
//
//  channel | direction | handshake            | beat
//  --------+-----------+----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o  | table write or one scan byte
//  out     | output    | out_valid_o/out_stall_i| match report or end-of-buffer total
//
// A scan byte first reads the goto table. When that step lands on the root it ends there,
// else it reads node info for each chain node and a pattern for each match, then
// flushes the held match; a closing total follows in either case for the last byte. The
// goto, node-info and pattern memories each give one registered read per cycle.
// Reset clears walk node, offset and count; the tables hold garbage until written.
// A stalled output holds the sequencer only when a new result must be handed over.
module multi_pattern_byte_scanner_unit #(
  parameter int unsigned NODES     = 1024,
  parameter int unsigned PATTERNS  = 1024,
  parameter int unsigned MAX_CHAIN = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  mpbs_pkg::op_e                         operation_i,
  input  logic [mpbs_pkg::FIELD_W-1:0]          node_i,
  input  logic [7:0]                            symbol_i,
  input  logic [mpbs_pkg::FIELD_W-1:0]          next_node_i,
  input  logic [mpbs_pkg::FIELD_W-1:0]          output_next_i,
  input  logic                                  has_pattern_i,
  input  logic [mpbs_pkg::FIELD_W-1:0]          pattern_slot_i,
  input  logic [mpbs_pkg::WORD_W-1:0]           pattern_id_i,
  input  logic [mpbs_pkg::WORD_W-1:0]           pattern_len_i,
  input  logic                                  first_byte_i,
  input  logic                                  last_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  kind_o,
  output logic [mpbs_pkg::WORD_W-1:0]           match_id_o,
  output logic [mpbs_pkg::WORD_W-1:0]           match_len_o,
  output logic [mpbs_pkg::WORD_W-1:0]           byte_offset_o,
  output logic [mpbs_pkg::WORD_W-1:0]           match_total_o,
  output logic                                  final_of_run_o
);
  import mpbs_pkg::*;
  `include "multi_pattern_byte_scanner_unit_macros.svh"

  localparam int unsigned NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned PSW = (PATTERNS > 1) ? $clog2(PATTERNS) : 1;
  localparam int unsigned SW  = $clog2(MAX_CHAIN + 1);
  localparam int unsigned GOTO_DEPTH = NODES * 256;
  localparam logic [31:0] NODES_L    = 32'(NODES);
  localparam logic [31:0] PATTERNS_L = 32'(PATTERNS);
  localparam logic [SW-1:0] STEP_MAX = SW'(MAX_CHAIN);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GOTO  = 3'd1;
  localparam logic [2:0] ST_INFO  = 3'd2;
  localparam logic [2:0] ST_PAT   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_CLOSE = 3'd5;

  typedef struct packed {
    logic [NW-1:0]  link;
    logic           hit;
    logic [PSW-1:0] slot;
  } info_t;

  // tables
  logic [NW-1:0]  goto_mem [GOTO_DEPTH];
  info_t          info_mem [NODES];
  logic [63:0]    pat_mem  [PATTERNS];

  logic [2:0]        state_q, state_d;
  logic [NW-1:0]     walk_q, walk_d;
  logic [WORD_W-1:0] off_q, off_d;
  logic [WORD_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0] scan_off_q, scan_off_d;
  logic              last_q, last_d;
  logic [SW-1:0]     steps_q, steps_d;
  logic              pend_valid_q, pend_valid_d;
  res_t              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  res_t              out_q, out_d;
  logic [NW-1:0]     goto_rd_q;
  info_t             info_q;
  logic [63:0]       pat_rd_q;

  logic              in_acc, out_free, out_load;
  res_t              out_new;
  logic              goto_we, info_we, pat_we;
  logic              goto_re, info_re, pat_re;
  logic [NW+7:0]     goto_wa, goto_ra;
  logic [NW-1:0]     walk_eff, info_ra;
  logic [NW-1:0]     next_ok, link_ok;
  info_t             info_wd;
  logic              node_in_range, slot_in_range;
  logic [SW-1:0]     steps_nx;
  logic              chain_end;
  logic [WORD_W-1:0] cnt_inc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign node_in_range = (32'(node_i) < NODES_L);
  assign slot_in_range = (32'(pattern_slot_i) < PATTERNS_L);
  assign next_ok = (32'(next_node_i) < NODES_L) ? NW'(next_node_i) : '0;
  assign link_ok = (32'(output_next_i) < NODES_L) ? NW'(output_next_i) : '0;

  assign goto_we = in_acc && (operation_i == OP_WR_GOTO) && node_in_range;
  assign info_we = in_acc && (operation_i == OP_WR_NODE) && node_in_range;
  assign pat_we  = in_acc && (operation_i == OP_WR_PAT) && slot_in_range;
  assign goto_wa = {NW'(node_i), symbol_i};

  assign info_wd.link = link_ok;
  assign info_wd.hit  = has_pattern_i && slot_in_range;
  assign info_wd.slot = PSW'(pattern_slot_i);

  assign walk_eff = first_byte_i ? '0 : walk_q;
  assign goto_ra  = {walk_eff, symbol_i};
  assign info_ra  = (state_q == ST_GOTO) ? goto_rd_q : info_q.link;

  assign steps_nx  = steps_q + SW'(1);
  assign chain_end = (info_q.link == '0);
  assign cnt_inc   = sat_inc(cnt_q);

  always_ff @(posedge clk_i) begin
    if (goto_we) begin
      goto_mem[goto_wa] <= next_ok;
    end
    if (goto_re) begin
      goto_rd_q <= goto_mem[goto_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[NW'(node_i)] <= info_wd;
    end
    if (info_re) begin
      info_q <= info_mem[info_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[PSW'(pattern_slot_i)] <= {pattern_id_i, pattern_len_i};
    end
    if (pat_re) begin
      pat_rd_q <= pat_mem[info_q.slot];
    end
  end

  always_comb begin
    state_d      = state_q;
    walk_d       = walk_q;
    off_d        = off_q;
    cnt_d        = cnt_q;
    scan_off_d   = scan_off_q;
    last_d       = last_q;
    steps_d      = steps_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    goto_re      = 1'b0;
    info_re      = 1'b0;
    pat_re       = 1'b0;
    out_load     = 1'b0;
    out_new      = pend_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (operation_i == OP_SCAN)) begin
          goto_re    = 1'b1;
          scan_off_d = first_byte_i ? '0 : off_q;
          off_d      = sat_inc(first_byte_i ? '0 : off_q);
          cnt_d      = first_byte_i ? '0 : cnt_q;
          last_d     = last_byte_i;
          steps_d    = '0;
          state_d    = ST_GOTO;
        end
      end
      ST_GOTO: begin
        walk_d = goto_rd_q;
        if (goto_rd_q == '0) begin
          state_d = last_q ? ST_CLOSE : ST_IDLE;
        end else begin
          info_re = 1'b1;
          state_d = ST_INFO;
        end
      end
      ST_INFO: begin
        steps_d = steps_nx;
        if (info_q.hit) begin
          pat_re  = 1'b1;
          state_d = ST_PAT;
        end else if ((steps_nx == STEP_MAX) || chain_end) begin
          state_d = ST_FLUSH;
        end else begin
          info_re = 1'b1;
        end
      end
      ST_PAT: begin
        if (!pend_valid_q || out_free) begin
          // hand the held match over, then hold the new one
          out_load           = pend_valid_q;
          out_new.final_run  = 1'b0;
          pend_valid_d       = 1'b1;
          pend_d.kind        = KIND_MATCH;
          pend_d.id          = pat_rd_q[63:32];
          pend_d.len         = pat_rd_q[31:0];
          pend_d.offset      = scan_off_q;
          pend_d.total       = cnt_inc;
          pend_d.final_run   = 1'b0;
          cnt_d              = cnt_inc;
          if ((steps_q == STEP_MAX) || chain_end) begin
            state_d = ST_FLUSH;
          end else begin
            info_re = 1'b1;
            state_d = ST_INFO;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = last_q ? ST_CLOSE : ST_IDLE;
        end else if (out_free) begin
          out_load          = 1'b1;
          out_new.final_run = !last_q;
          pend_valid_d      = 1'b0;
          state_d           = last_q ? ST_CLOSE : ST_IDLE;
        end
      end
      ST_CLOSE: begin
        out_new.kind      = KIND_END;
        out_new.id        = '0;
        out_new.len       = '0;
        out_new.offset    = scan_off_q;
        out_new.total     = cnt_q;
        out_new.final_run = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_d = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = out_new;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      walk_q       <= '0;
      off_q        <= '0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
      steps_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      walk_q       <= walk_d;
      off_q        <= off_d;
      cnt_q        <= cnt_d;
      last_q       <= last_d;
      steps_q      <= steps_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_off_q <= scan_off_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign match_id_o     = out_q.id;
  assign match_len_o    = out_q.len;
  assign byte_offset_o  = out_q.offset;
  assign match_total_o  = out_q.total;
  assign final_of_run_o = out_q.final_run;

  `MPBS_ASSERT_IMP(a_idle_no_pending, clk_i, rst_ni, state_q == ST_IDLE, !pend_valid_q)
  `MPBS_ASSERT_IMP(a_steps_bounded, clk_i, rst_ni, 1'b1, steps_q <= STEP_MAX)
  `MPBS_ASSERT_NXT(a_count_monotonic, clk_i, rst_ni, state_q != ST_IDLE, cnt_q >= $past(cnt_q))
  `MPBS_ASSERT_IMP(a_close_needs_last, clk_i, rst_ni, state_q == ST_CLOSE, last_q)

endmodule
